>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/cffi_pkg.sv
// ----------------------------------------------------------------------------
// cffi_pkg
// Types and constants of the credit flow flit injector.
// ----------------------------------------------------------------------------
package cffi_pkg;

   localparam int NUM_VC      = 4;
   localparam int VC_W        = 2;
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = PTR_W + 1;
   localparam int MAX_FLITS   = 16;

   localparam logic [1:0] REQ_GEN  = 2'd0;
   localparam logic [1:0] REQ_SEND = 2'd1;
   localparam logic [1:0] REQ_ARR  = 2'd2;
   localparam logic [1:0] REQ_NONE = 2'd3;

   localparam logic [1:0] REG_PACKET_FLITS   = 2'd0;
   localparam logic [1:0] REG_INITIAL_CREDIT = 2'd1;
   localparam logic [1:0] REG_QUEUE_LIMIT    = 2'd2;
   localparam logic [1:0] REG_NODE_NUMBER    = 2'd3;

   localparam logic [2:0] ST_QUEUED    = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_SENT      = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;
   localparam logic [2:0] ST_NOCREDIT  = 3'd5;
   localparam logic [2:0] ST_RECEIVED  = 3'd6;
   localparam logic [2:0] ST_WRONGDEST = 3'd7;

   typedef struct packed {
      logic        is_head;
      logic        is_tail;
      logic [1:0]  vc;
      logic [15:0] seq;
      logic [7:0]  dest;
   } flit_entry_type;

   localparam int ENTRY_W = $bits(flit_entry_type);

   typedef struct packed {
      logic capture;
      logic decide;
      logic write_flit;
   } cffi_cmd_type;

   typedef struct packed {
      logic is_gen;
      logic gen_fits;
      logic last_flit;
   } cffi_stat_type;

endpackage

>>> sv/credit_flow_flit_injector.sv
// ----------------------------------------------------------------------------
// credit_flow_flit_injector
// Network-on-chip injection port with per-virtual-channel credit flow control.
// ----------------------------------------------------------------------------
// Send tick, flit arrival, idle request, dropped packet: capture, decide, result.
// Queued packet: capture, decide, then one send queue RAM write per flit.
// One transaction at a time; the next start is taken as the result shows.
// Result strobe rsp_valid lasts one cycle; the receiver cannot stall.
// Reset (synchronous): queue empty, sequence 0, credits and registers at defaults.
module credit_flow_flit_injector (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_gen_dest,
   input  logic        req_link_busy,
   input  logic [7:0]  req_arr_dest,
   input  logic        req_arr_is_tail,
   input  logic        req_arr_credit_valid,
   input  logic [1:0]  req_arr_credit_vc,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_flit_valid,
   output logic        rsp_flit_is_head,
   output logic        rsp_flit_is_tail,
   output logic [1:0]  rsp_flit_vc,
   output logic [15:0] rsp_flit_seq,
   output logic [7:0]  rsp_flit_dest,
   output logic [6:0]  rsp_queue_level,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   cffi_pkg::cffi_cmd_type  cmd;
   cffi_pkg::cffi_stat_type stat;
   logic                    csr_we;

   assign csr_ready = ~busy;
   assign csr_we    = csr_valid & ~busy;

   cffi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   cffi_datapath u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_type             (req_type),
      .req_gen_dest         (req_gen_dest),
      .req_link_busy        (req_link_busy),
      .req_arr_dest         (req_arr_dest),
      .req_arr_credit_valid (req_arr_credit_valid),
      .req_arr_credit_vc    (req_arr_credit_vc),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_flit_valid       (rsp_flit_valid),
      .rsp_flit_is_head     (rsp_flit_is_head),
      .rsp_flit_is_tail     (rsp_flit_is_tail),
      .rsp_flit_vc          (rsp_flit_vc),
      .rsp_flit_seq         (rsp_flit_seq),
      .rsp_flit_dest        (rsp_flit_dest),
      .rsp_queue_level      (rsp_queue_level)
   );

endmodule

>>> sv/cffi_ram.sv
// ----------------------------------------------------------------------------
// cffi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module cffi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/cffi_datapath.sv
// ----------------------------------------------------------------------------
// cffi_datapath
// Configuration registers, credits, send queue pointers and result register.
// ----------------------------------------------------------------------------
module cffi_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  cffi_pkg::cffi_cmd_type  cmd,
   output cffi_pkg::cffi_stat_type stat,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [7:0]              csr_data,
   input  logic [1:0]              req_type,
   input  logic [7:0]              req_gen_dest,
   input  logic                    req_link_busy,
   input  logic [7:0]              req_arr_dest,
   input  logic                    req_arr_credit_valid,
   input  logic [1:0]              req_arr_credit_vc,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic                    rsp_flit_valid,
   output logic                    rsp_flit_is_head,
   output logic                    rsp_flit_is_tail,
   output logic [1:0]              rsp_flit_vc,
   output logic [15:0]             rsp_flit_seq,
   output logic [7:0]              rsp_flit_dest,
   output logic [6:0]              rsp_queue_level
);

   localparam int VC_W  = cffi_pkg::VC_W;
   localparam int PTR_W = cffi_pkg::PTR_W;
   localparam int CNT_W = cffi_pkg::CNT_W;

   // configuration
   logic [4:0] packet_flits_ff, packet_flits_in;
   logic [7:0] initial_credit_ff, initial_credit_in;
   logic [6:0] queue_limit_ff, queue_limit_in;
   logic [7:0] node_number_ff, node_number_in;

   // captured transaction
   logic [1:0] type_ff;
   logic [7:0] gen_dest_ff;
   logic       link_busy_ff;
   logic [7:0] arr_dest_ff;
   logic       arr_credit_valid_ff;
   logic [1:0] arr_credit_vc_ff;

   // queue and credit state
   logic [7:0]       credit_ff [cffi_pkg::NUM_VC];
   logic [7:0]       credit_in [cffi_pkg::NUM_VC];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      seq_ff, seq_in;
   logic [VC_W-1:0]  gen_vc_ff, gen_vc_in;
   logic [3:0]       idx_ff, idx_in;

   // result
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic        fvalid_ff, fvalid_in;
   logic        fhead_ff, fhead_in;
   logic        ftail_ff, ftail_in;
   logic [1:0]  fvc_ff, fvc_in;
   logic [15:0] fseq_ff, fseq_in;
   logic [7:0]  fdest_ff, fdest_in;
   logic [6:0]  level_ff, level_in;

   logic                     ram_we;
   logic [cffi_pkg::ENTRY_W-1:0] ram_rdata;
   cffi_pkg::flit_entry_type wr_entry;
   cffi_pkg::flit_entry_type rd_entry;

   logic [4:0]      pkt_len;
   logic [6:0]      cap;
   logic            gen_fits;
   logic            last_flit;
   logic [VC_W-1:0] best_vc;
   logic [7:0]      best_credit;
   logic [7:0]      sel_credit;
   logic            send_ok;
   logic            ret_ok;

   cffi_ram #(
      .WIDTH (cffi_pkg::ENTRY_W),
      .DEPTH (cffi_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .we    (ram_we),
      .waddr (tail_ff),
      .wdata (wr_entry),
      .raddr (head_ff),
      .rdata (ram_rdata)
   );

   assign rd_entry = cffi_pkg::flit_entry_type'(ram_rdata);

   always_comb begin
      if (packet_flits_ff == 5'd0) begin
         pkt_len = 5'd1;
      end else if (packet_flits_ff > 5'(cffi_pkg::MAX_FLITS)) begin
         pkt_len = 5'(cffi_pkg::MAX_FLITS);
      end else begin
         pkt_len = packet_flits_ff;
      end
   end

   assign cap = (queue_limit_ff < 7'(cffi_pkg::QUEUE_DEPTH)) ?
                queue_limit_ff : 7'(cffi_pkg::QUEUE_DEPTH);
   assign gen_fits  = ({1'b0, count_ff} + {3'b000, pkt_len}) <= {1'b0, cap};
   assign last_flit = idx_ff == 4'(pkt_len - 5'd1);

   always_comb begin
      best_vc     = '0;
      best_credit = '0;
      for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
         if (credit_ff[v] > best_credit) begin
            best_credit = credit_ff[v];
            best_vc     = VC_W'(v);
         end
      end
   end

   assign sel_credit = credit_ff[rd_entry.vc];
   assign send_ok    = (count_ff != '0) && !link_busy_ff && (sel_credit != 8'd0);
   assign ret_ok     = arr_credit_valid_ff &&
                       (32'(arr_credit_vc_ff) < cffi_pkg::NUM_VC);

   assign wr_entry.is_head = idx_ff == 4'd0;
   assign wr_entry.is_tail = last_flit;
   assign wr_entry.vc      = gen_vc_ff;
   assign wr_entry.seq     = seq_ff;
   assign wr_entry.dest    = gen_dest_ff;

   always_comb begin
      packet_flits_in   = packet_flits_ff;
      initial_credit_in = initial_credit_ff;
      queue_limit_in    = queue_limit_ff;
      node_number_in    = node_number_ff;
      credit_in         = credit_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      seq_in            = seq_ff;
      gen_vc_in         = gen_vc_ff;
      idx_in            = idx_ff;
      ram_we            = 1'b0;
      rsp_valid_in      = 1'b0;
      status_in         = cffi_pkg::ST_EMPTY;
      fvalid_in         = 1'b0;
      fhead_in          = 1'b0;
      ftail_in          = 1'b0;
      fvc_in            = '0;
      fseq_in           = '0;
      fdest_in          = '0;
      level_in          = 7'(count_ff);

      if (csr_we) begin
         unique case (csr_index)
            cffi_pkg::REG_PACKET_FLITS: begin
               packet_flits_in = csr_data[4:0];
            end
            cffi_pkg::REG_INITIAL_CREDIT: begin
               initial_credit_in = csr_data;
               for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
                  credit_in[v] = csr_data;
               end
            end
            cffi_pkg::REG_QUEUE_LIMIT: begin
               queue_limit_in = csr_data[6:0];
            end
            cffi_pkg::REG_NODE_NUMBER: begin
               node_number_in = csr_data;
            end
            default: begin
            end
         endcase
      end

      if (cmd.decide) begin
         unique case (type_ff)
            cffi_pkg::REQ_GEN: begin
               if (gen_fits) begin
                  gen_vc_in = best_vc;
                  idx_in    = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = cffi_pkg::ST_DROPPED;
               end
            end
            cffi_pkg::REQ_SEND: begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  status_in = cffi_pkg::ST_EMPTY;
               end else if (link_busy_ff) begin
                  status_in = cffi_pkg::ST_BUSY;
               end else if (!send_ok) begin
                  status_in = cffi_pkg::ST_NOCREDIT;
               end else begin
                  for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
                     if (rd_entry.vc == VC_W'(v)) begin
                        credit_in[v] = credit_ff[v] - 8'd1;
                     end
                  end
                  head_in   = head_ff + PTR_W'(1);
                  count_in  = count_ff - CNT_W'(1);
                  status_in = cffi_pkg::ST_SENT;
                  fvalid_in = 1'b1;
                  fhead_in  = rd_entry.is_head;
                  ftail_in  = rd_entry.is_tail;
                  fvc_in    = rd_entry.vc;
                  fseq_in   = rd_entry.seq;
                  fdest_in  = rd_entry.dest;
                  level_in  = 7'(count_ff - CNT_W'(1));
               end
            end
            cffi_pkg::REQ_ARR: begin
               rsp_valid_in = 1'b1;
               status_in    = (arr_dest_ff == node_number_ff) ?
                              cffi_pkg::ST_RECEIVED : cffi_pkg::ST_WRONGDEST;
               for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
                  if (ret_ok && (arr_credit_vc_ff == VC_W'(v)) &&
                      (credit_ff[v] != 8'hFF)) begin
                     credit_in[v] = credit_ff[v] + 8'd1;
                  end
               end
            end
            cffi_pkg::REQ_NONE: begin
               rsp_valid_in = 1'b1;
               status_in    = (count_ff == '0) ? cffi_pkg::ST_EMPTY : cffi_pkg::ST_BUSY;
            end
            default: begin
            end
         endcase
      end

      if (cmd.write_flit) begin
         ram_we   = 1'b1;
         tail_in  = tail_ff + PTR_W'(1);
         count_in = count_ff + CNT_W'(1);
         seq_in   = seq_ff + 16'd1;
         idx_in   = idx_ff + 4'd1;
         if (last_flit) begin
            rsp_valid_in = 1'b1;
            status_in    = cffi_pkg::ST_QUEUED;
            fvc_in       = gen_vc_ff;
            level_in     = 7'(count_ff + CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_flits_ff   <= 5'd4;
         initial_credit_ff <= 8'd8;
         queue_limit_ff    <= 7'd64;
         node_number_ff    <= 8'd0;
         for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
            credit_ff[v] <= 8'd8;
         end
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         packet_flits_ff   <= packet_flits_in;
         initial_credit_ff <= initial_credit_in;
         queue_limit_ff    <= queue_limit_in;
         node_number_ff    <= node_number_in;
         credit_ff         <= credit_in;
         head_ff           <= head_in;
         tail_ff           <= tail_in;
         count_ff          <= count_in;
         seq_ff            <= seq_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff             <= req_type;
         gen_dest_ff         <= req_gen_dest;
         link_busy_ff        <= req_link_busy;
         arr_dest_ff         <= req_arr_dest;
         arr_credit_valid_ff <= req_arr_credit_valid;
         arr_credit_vc_ff    <= req_arr_credit_vc;
      end
      gen_vc_ff <= gen_vc_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      fvalid_ff <= fvalid_in;
      fhead_ff  <= fhead_in;
      ftail_ff  <= ftail_in;
      fvc_ff    <= fvc_in;
      fseq_ff   <= fseq_in;
      fdest_ff  <= fdest_in;
      level_ff  <= level_in;
   end

   assign stat.is_gen    = type_ff == cffi_pkg::REQ_GEN;
   assign stat.gen_fits  = gen_fits;
   assign stat.last_flit = last_flit;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_flit_valid   = fvalid_ff;
   assign rsp_flit_is_head = fhead_ff;
   assign rsp_flit_is_tail = ftail_ff;
   assign rsp_flit_vc      = fvc_ff;
   assign rsp_flit_seq     = fseq_ff;
   assign rsp_flit_dest    = fdest_ff;
   assign rsp_queue_level  = level_ff;

endmodule

>>> sv/cffi_ctrl.sv
// ----------------------------------------------------------------------------
// cffi_ctrl
// Sequencer: capture, decide, then for a fitting packet one queue write per flit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cffi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output cffi_pkg::cffi_cmd_type  cmd,
   input  cffi_pkg::cffi_stat_type stat
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_WRITE  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd.capture     = 1'b0;
      cmd.decide      = 1'b0;
      cmd.write_flit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = (stat.is_gen && stat.gen_fits) ? S_WRITE : S_IDLE;
         end
         S_WRITE: begin
            cmd.write_flit = 1'b1;
            if (stat.last_flit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   `ASSERT_CLK(a_start_goes_busy, clock, reset, (start && !busy) |=> busy, "accept did not raise busy")
   `ASSERT_CLK(a_write_only_gen, clock, reset, (state_ff == S_WRITE) |-> stat.is_gen, "queue write outside generate")
   `ASSERT_CLK(a_nongen_one_decide, clock, reset, (state_ff == S_DECIDE && !stat.is_gen) |=> (state_ff == S_IDLE), "non-generate transaction took more than one decide cycle")
   `ASSERT_ALWAYS(a_cmd_exclusive, clock, $onehot0({cmd.capture, cmd.decide, cmd.write_flit}), "overlapping datapath commands")

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the credit flow flit injector against a transaction-level predictor.
// A directed sequence covers empty queue, busy link, missing credit, channel
// ties, single-flit and largest packets, drops, wrong destination and credit
// saturation. Random phases then sweep the registers, with sender idle bursts,
// and every result is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 116;
   localparam int DRAIN_CYCLES    = 30;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] gen_dest;
      logic       link_busy;
      logic [7:0] arr_dest;
      logic       arr_is_tail;
      logic       arr_credit_valid;
      logic [1:0] arr_credit_vc;
   } flit_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        flit_valid;
      logic        is_head;
      logic        is_tail;
      logic [1:0]  vc;
      logic [15:0] seq;
      logic [7:0]  dest;
      logic [6:0]  level;
   } flit_result_type;

   class flit_injector_predictor;
      logic [4:0]               packet_flits;
      logic [7:0]               initial_credit;
      logic [6:0]               queue_limit;
      logic [7:0]               node_number;
      logic [7:0]               credits[cffi_pkg::NUM_VC];
      cffi_pkg::flit_entry_type send_queue[cffi_pkg::QUEUE_DEPTH];
      logic [5:0]               sq_head;
      logic [6:0]               sq_count;
      logic [15:0]              next_seq;
      flit_result_type          expected_results[8];
      logic [2:0]               exp_head;
      logic [3:0]               exp_count;
      int                       errors;

      function new();
         packet_flits   = 5'd4;
         initial_credit = 8'd8;
         queue_limit    = 7'd64;
         node_number    = 8'd0;
         foreach (credits[v]) credits[v] = 8'd8;
         sq_head   = '0;
         sq_count  = '0;
         next_seq  = '0;
         exp_head  = '0;
         exp_count = '0;
         errors    = 0;
      endfunction

      function int pending();
         return int'(exp_count);
      endfunction

      function void write_reg(logic [1:0] index, logic [7:0] data);
         case (index)
            cffi_pkg::REG_PACKET_FLITS: packet_flits = data[4:0];
            cffi_pkg::REG_INITIAL_CREDIT: begin
               initial_credit = data;
               foreach (credits[v]) credits[v] = data;
            end
            cffi_pkg::REG_QUEUE_LIMIT: queue_limit = data[6:0];
            cffi_pkg::REG_NODE_NUMBER: node_number = data;
            default: ;
         endcase
      endfunction

      function void note_request(flit_request_type rq);
         flit_result_type          res;
         cffi_pkg::flit_entry_type e;
         logic [5:0]               wr_ptr;
         int                       len;
         int                       cap;
         int                       best;
         int                       most;
         res = '0;
         case (rq.kind)
            cffi_pkg::REQ_GEN: begin
               len = int'(packet_flits);
               if (len < 1) len = 1;
               if (len > cffi_pkg::MAX_FLITS) len = cffi_pkg::MAX_FLITS;
               cap = (int'(queue_limit) < cffi_pkg::QUEUE_DEPTH) ? int'(queue_limit)
                                                                 : cffi_pkg::QUEUE_DEPTH;
               if (int'(sq_count) + len <= cap) begin
                  best = 0;
                  most = 0;
                  for (int v = 0; v < cffi_pkg::NUM_VC; v++) begin
                     if (int'(credits[v]) > most) begin
                        most = int'(credits[v]);
                        best = v;
                     end
                  end
                  for (int i = 0; i < len; i++) begin
                     e.is_head = (i == 0);
                     e.is_tail = (i == len - 1);
                     e.vc      = best[1:0];
                     e.seq     = next_seq;
                     e.dest    = rq.gen_dest;
                     wr_ptr    = sq_head + sq_count[5:0];
                     send_queue[wr_ptr] = e;
                     sq_count  = sq_count + 7'd1;
                     next_seq  = next_seq + 16'd1;
                  end
                  res.status = cffi_pkg::ST_QUEUED;
                  res.vc     = best[1:0];
               end else begin
                  res.status = cffi_pkg::ST_DROPPED;
               end
            end
            cffi_pkg::REQ_SEND: begin
               if (sq_count == 7'd0) begin
                  res.status = cffi_pkg::ST_EMPTY;
               end else if (rq.link_busy) begin
                  res.status = cffi_pkg::ST_BUSY;
               end else begin
                  e = send_queue[sq_head];
                  if (credits[e.vc] == 8'd0) begin
                     res.status = cffi_pkg::ST_NOCREDIT;
                  end else begin
                     credits[e.vc]  = credits[e.vc] - 8'd1;
                     sq_head        = sq_head + 6'd1;
                     sq_count       = sq_count - 7'd1;
                     res.status     = cffi_pkg::ST_SENT;
                     res.flit_valid = 1'b1;
                     res.is_head    = e.is_head;
                     res.is_tail    = e.is_tail;
                     res.vc         = e.vc;
                     res.seq        = e.seq;
                     res.dest       = e.dest;
                  end
               end
            end
            cffi_pkg::REQ_ARR: begin
               res.status = (rq.arr_dest != node_number) ? cffi_pkg::ST_WRONGDEST
                                                         : cffi_pkg::ST_RECEIVED;
               if (rq.arr_credit_valid && int'(rq.arr_credit_vc) < cffi_pkg::NUM_VC &&
                   credits[rq.arr_credit_vc] < 8'd255)
                  credits[rq.arr_credit_vc] = credits[rq.arr_credit_vc] + 8'd1;
            end
            default: res.status = (sq_count == 7'd0) ? cffi_pkg::ST_EMPTY
                                                     : cffi_pkg::ST_BUSY;
         endcase
         res.level = sq_count;
         expected_results[exp_head + exp_count[2:0]] = res;
         exp_count = exp_count + 4'd1;
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_response(flit_result_type got);
         flit_result_type want;
         if (exp_count == 4'd0) begin
            report("result with no transaction outstanding");
            return;
         end
         want      = expected_results[exp_head];
         exp_head  = exp_head + 3'd1;
         exp_count = exp_count - 4'd1;
         check_field("status", 16'(got.status), 16'(want.status));
         check_field("flit_valid", 16'(got.flit_valid), 16'(want.flit_valid));
         check_field("flit_is_head", 16'(got.is_head), 16'(want.is_head));
         check_field("flit_is_tail", 16'(got.is_tail), 16'(want.is_tail));
         check_field("flit_vc", 16'(got.vc), 16'(want.vc));
         check_field("flit_seq", got.seq, want.seq);
         check_field("flit_dest", 16'(got.dest), 16'(want.dest));
         check_field("queue_level", 16'(got.level), 16'(want.level));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = cffi_pkg::REQ_NONE;
   logic [7:0]  req_gen_dest = '0;
   logic        req_link_busy = 1'b0;
   logic [7:0]  req_arr_dest = '0;
   logic        req_arr_is_tail = 1'b0;
   logic        req_arr_credit_valid = 1'b0;
   logic [1:0]  req_arr_credit_vc = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic        rsp_flit_valid;
   logic        rsp_flit_is_head;
   logic        rsp_flit_is_tail;
   logic [1:0]  rsp_flit_vc;
   logic [15:0] rsp_flit_seq;
   logic [7:0]  rsp_flit_dest;
   logic [6:0]  rsp_queue_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int unsigned            cycle_count = 0;
   flit_injector_predictor predictor;

   credit_flow_flit_injector u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_gen_dest         (req_gen_dest),
      .req_link_busy        (req_link_busy),
      .req_arr_dest         (req_arr_dest),
      .req_arr_is_tail      (req_arr_is_tail),
      .req_arr_credit_valid (req_arr_credit_valid),
      .req_arr_credit_vc    (req_arr_credit_vc),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_flit_valid       (rsp_flit_valid),
      .rsp_flit_is_head     (rsp_flit_is_head),
      .rsp_flit_is_tail     (rsp_flit_is_tail),
      .rsp_flit_vc          (rsp_flit_vc),
      .rsp_flit_seq         (rsp_flit_seq),
      .rsp_flit_dest        (rsp_flit_dest),
      .rsp_queue_level      (rsp_queue_level),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && predictor != null)
         predictor.check_response(flit_result_type'({rsp_status, rsp_flit_valid,
                                  rsp_flit_is_head, rsp_flit_is_tail, rsp_flit_vc,
                                  rsp_flit_seq, rsp_flit_dest, rsp_queue_level}));
   end

   function automatic int idle_gap(bit quiet);
      if (quiet || $urandom_range(0, 3) != 0) return 0;
      return int'($urandom_range(1, 18));
   endfunction

   function automatic flit_request_type gen_req(logic [7:0] dest);
      flit_request_type rq;
      rq          = '0;
      rq.kind     = cffi_pkg::REQ_GEN;
      rq.gen_dest = dest;
      return rq;
   endfunction

   function automatic flit_request_type tick_req(logic link_busy);
      flit_request_type rq;
      rq           = '0;
      rq.kind      = cffi_pkg::REQ_SEND;
      rq.link_busy = link_busy;
      return rq;
   endfunction

   function automatic flit_request_type none_req();
      flit_request_type rq;
      rq      = '0;
      rq.kind = cffi_pkg::REQ_NONE;
      return rq;
   endfunction

   function automatic flit_request_type arr_req(logic [7:0] dest, logic tail,
                                                logic credit_valid, logic [1:0] vc);
      flit_request_type rq;
      rq                  = '0;
      rq.kind             = cffi_pkg::REQ_ARR;
      rq.arr_dest         = dest;
      rq.arr_is_tail      = tail;
      rq.arr_credit_valid = credit_valid;
      rq.arr_credit_vc    = vc;
      return rq;
   endfunction

   // Entered and left on a rising edge; start stays high into the next
   // transaction when there is no gap.
   task automatic drive_request(flit_request_type rq, int gap);
      req_type             <= rq.kind;
      req_gen_dest         <= rq.gen_dest;
      req_link_busy        <= rq.link_busy;
      req_arr_dest         <= rq.arr_dest;
      req_arr_is_tail      <= rq.arr_is_tail;
      req_arr_credit_valid <= rq.arr_credit_valid;
      req_arr_credit_vc    <= rq.arr_credit_vc;
      start                <= 1'b1;
      do @(posedge clock); while (busy);
      predictor.note_request(rq);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_settings(logic [7:0] flits, logic [7:0] credit,
                                 logic [7:0] limit, logic [7:0] node);
      logic [7:0] values[4];
      values = '{flits, credit, limit, node};
      for (int i = 0; i < 4; i++) begin
         csr_index <= i[1:0];
         csr_data  <= values[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         predictor.write_reg(i[1:0], values[i]);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (predictor.pending() > 0 || busy) @(posedge clock);
   endtask

   initial begin
      flit_request_type rq;
      logic [7:0]       flits;
      logic [7:0]       credit;
      logic [7:0]       limit;
      logic [7:0]       node;
      int               r;
      bit               quiet;

      predictor = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-flit packets, one credit per channel
      write_settings(8'd1, 8'd1, 8'd64, 8'hA5);
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(none_req(), idle_gap(0));
      drive_request(gen_req(8'hFF), idle_gap(0));
      drive_request(none_req(), idle_gap(0));
      drive_request(tick_req(1'b1), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(gen_req(8'h00), idle_gap(0));
      drive_request(gen_req(8'h00), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(arr_req(8'hA5, 1'b1, 1'b1, 2'd1), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(gen_req(8'h7E), idle_gap(0));
      drive_request(gen_req(8'h81), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      // channels 0 to 2 out of credit: channel 3 is chosen
      drive_request(gen_req(8'h33), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      drive_request(arr_req(8'h5A, 1'b0, 1'b1, 2'd0), idle_gap(0));
      drive_request(arr_req(8'hA5, 1'b0, 1'b0, 2'd2), idle_gap(0));
      drive_request(tick_req(1'b0), idle_gap(0));
      wait_idle();

      // directed: largest packet, tight limit, saturated credit
      write_settings(8'd16, 8'd255, 8'd20, 8'hA5);
      drive_request(gen_req(8'hC3), idle_gap(0));
      drive_request(gen_req(8'h3C), idle_gap(0));
      drive_request(arr_req(8'hA5, 1'b1, 1'b1, 2'd0), idle_gap(0));
      drive_request(tick_req(1'b0), 0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         node = 8'($urandom_range(0, 255));
         case (p)
            0: begin flits = 8'd4; credit = 8'd8; limit = 8'd64; node = 8'd0; end
            1: begin flits = 8'd16; credit = 8'd255; limit = 8'd127; node = 8'd255; end
            2: begin flits = 8'd0; credit = 8'd1; limit = 8'd1; end
            3: begin flits = 8'd31; credit = 8'd2; limit = 8'd20; end
            4: begin
               flits  = 8'($urandom_range(1, 16));
               credit = 8'($urandom_range(1, 255));
               limit  = 8'($urandom_range(1, 64));
            end
            5: begin flits = 8'($urandom_range(0, 255)); credit = 8'd5; limit = 8'd0; end
            6: begin
               flits  = 8'($urandom_range(0, 255));
               credit = 8'($urandom_range(1, 255));
               limit  = 8'($urandom_range(0, 255));
            end
            default: begin flits = 8'd2; credit = 8'd3; limit = 8'd64; end
         endcase
         write_settings(flits, credit, limit, node);
         quiet = (p == NUM_PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            r = int'($urandom_range(0, 99));
            if (r < 30)      rq.kind = cffi_pkg::REQ_GEN;
            else if (r < 70) rq.kind = cffi_pkg::REQ_SEND;
            else if (r < 95) rq.kind = cffi_pkg::REQ_ARR;
            else             rq.kind = cffi_pkg::REQ_NONE;
            rq.gen_dest         = 8'($urandom_range(0, 255));
            rq.link_busy        = ($urandom_range(0, 3) == 0);
            rq.arr_dest         = ($urandom_range(0, 2) != 0) ? predictor.node_number
                                                              : 8'($urandom_range(0, 255));
            rq.arr_is_tail      = 1'($urandom_range(0, 1));
            rq.arr_credit_valid = ($urandom_range(0, 9) < 7);
            rq.arr_credit_vc    = 2'($urandom_range(0, 3));
            drive_request(rq, idle_gap(quiet));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (predictor.errors == 0 && predictor.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
